@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, off during reset.
`define CSH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define CSH_ASSERT_IMPL(label, ante, cons, msg) \
    `CSH_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CSH_ASSERT_NEXT(label, ante, cons, msg) \
    `CSH_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ src/csh_pkg.sv @@
// Shared types, constants and helpers of the clock sweep replacer.
// Depends on nothing.
package csh_pkg;

    localparam int MAX_ENTRIES  = 1024;
    localparam int SWEEP_ROUNDS = 3;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int TRY_W        = $clog2(MAX_ENTRIES * SWEEP_ROUNDS + 1);
    localparam int ID_W         = 16;
    localparam int EC_W         = 11;
    localparam int CFG_W        = 16;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [1:0] USAGE_CAP = 2'd3;

    localparam logic [2:0] OP_HIT     = 3'd0;
    localparam logic [2:0] OP_EVICT   = 3'd1;
    localparam logic [2:0] OP_NEW_TAG = 3'd2;
    localparam logic [2:0] OP_VICTIM  = 3'd3;
    localparam logic [2:0] OP_UNPIN   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_FIRST_ID    = 1'b1;

    typedef enum logic [1:0] {
        K_UPDATE = 2'd0,
        K_VICTIM = 2'd1,
        K_RANGE  = 2'd2,
        K_NOP    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic             vac;
    } cmd_t;

    typedef struct packed {
        logic       pinned;
        logic       valid;
        logic [1:0] usage;
    } entry_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic [CNT_W-1:0] live_count(input logic [EC_W-1:0] ec);
        logic [CNT_W-1:0] n;
        if (ec == '0)
            n = CNT_W'(1);
        else if (32'(ec) > MAX_ENTRIES)
            n = CNT_W'(MAX_ENTRIES);
        else
            n = CNT_W'(ec);
        return n;
    endfunction

endpackage

@@ src/csh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module csh_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/csh_front.sv @@
// Front end: accept transactions, range-check ids, queue classified commands.
// Depends on csh_pkg.
module csh_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic [csh_pkg::ID_W-1:0]    buffer_id,
    input  logic                        vacuum_load,
    input  logic [csh_pkg::ID_W-1:0]    first_id,
    input  logic [csh_pkg::CNT_W-1:0]   live_n,
    input  csh_pkg::back_status_t       back_st,
    output logic                        cmd_valid,
    output csh_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);

    csh_pkg::cmd_t                q_reg [csh_pkg::QDEPTH];
    logic [csh_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [csh_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [csh_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [csh_pkg::ID_W:0]       diff;
    logic                         in_rng;
    logic                         push;
    csh_pkg::cmd_t                new_cmd;

    function automatic logic [csh_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
        return {{(csh_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign diff   = {1'b0, buffer_id} - {1'b0, first_id};
    assign in_rng = !diff[csh_pkg::ID_W]
                    && (diff[csh_pkg::ID_W-1:0] < csh_pkg::ID_W'(live_n));

    always_comb
    begin
        new_cmd.op  = operation;
        new_cmd.idx = diff[csh_pkg::IDX_W-1:0];
        new_cmd.vac = vacuum_load;
        if (operation == csh_pkg::OP_VICTIM)
            new_cmd.kind = csh_pkg::K_VICTIM;
        else if (operation > csh_pkg::OP_UNPIN)
            new_cmd.kind = csh_pkg::K_NOP;
        else if (!in_rng)
            new_cmd.kind = csh_pkg::K_RANGE;
        else
            new_cmd.kind = csh_pkg::K_UPDATE;
    end

    assign in_ready  = (cnt_reg != csh_pkg::QCNT_W'(csh_pkg::QDEPTH)) && !back_st.clearing;
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_ONE(push) - QCNT_ONE(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ src/csh_back.sv @@
// Back end: entry store, clearing pass, update and victim search sequencer.
// Depends on csh_pkg and csh_ram.
module csh_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  csh_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    input  logic [csh_pkg::CNT_W-1:0]   live_n,
    input  logic [csh_pkg::ID_W-1:0]    first_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [csh_pkg::ID_W-1:0]    victim_id,
    output logic [1:0]                  status,
    output csh_pkg::back_status_t       back_st
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_APPLY = 5'b00100,
        S_SCAN  = 5'b01000,
        S_SWEEP = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [csh_pkg::IDX_W-1:0]    clr_reg, clr_next;
    logic [csh_pkg::IDX_W-1:0]    cur_reg, cur_next;
    logic [csh_pkg::IDX_W-1:0]    hand_reg, hand_next;
    logic [csh_pkg::TRY_W-1:0]    tries_reg, tries_next;
    logic [csh_pkg::TRY_W-1:0]    tries_dec;
    logic [2:0]                   op_reg, op_next;
    logic                         vac_reg, vac_next;
    logic                         fwd_valid_reg, fwd_valid_next;
    csh_pkg::entry_t              fwd_data_reg, fwd_data_next;
    logic                         out_valid_reg, out_valid_next;
    logic [csh_pkg::ID_W-1:0]     victim_reg, victim_next;
    logic [1:0]                   status_reg, status_next;

    logic                         we;
    logic [csh_pkg::IDX_W-1:0]    waddr, raddr;
    csh_pkg::entry_t              wdata, e;
    logic [3:0]                   rdata;
    logic [csh_pkg::IDX_W-1:0]    start_c, next_c;
    logic [csh_pkg::CNT_W-1:0]    cur_inc, hand_inc;

    csh_ram #(.WIDTH(4), .DEPTH(csh_pkg::MAX_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign e         = fwd_valid_reg ? fwd_data_reg : csh_pkg::entry_t'(rdata);
    assign cur_inc   = csh_pkg::CNT_W'(cur_reg) + 1'b1;
    assign tries_dec = tries_reg - 1'b1;
    // Sweep start: a hand at or beyond the live count restarts at entry zero
    assign start_c   = (csh_pkg::CNT_W'(hand_reg) >= live_n) ? '0 : hand_reg;
    assign hand_inc  = csh_pkg::CNT_W'(start_c) + 1'b1;
    assign next_c    = (hand_inc >= live_n) ? '0 : hand_inc[csh_pkg::IDX_W-1:0];

    assign cmd_pop          = (state_reg == S_IDLE) && cmd_valid && !out_valid_reg;
    assign back_st.clearing = (state_reg == S_CLEAR);
    assign out_valid        = out_valid_reg;
    assign victim_id        = victim_reg;
    assign status           = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        hand_next      = hand_reg;
        tries_next     = tries_reg;
        op_next        = op_reg;
        vac_next       = vac_reg;
        out_valid_next = out_valid_reg && !out_ready;
        victim_next    = victim_reg;
        status_next    = status_reg;
        we             = 1'b0;
        waddr          = cur_reg;
        wdata          = e;
        raddr          = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == csh_pkg::IDX_W'(csh_pkg::MAX_ENTRIES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        csh_pkg::K_UPDATE:
                        begin
                            raddr      = cmd.idx;
                            cur_next   = cmd.idx;
                            op_next    = cmd.op;
                            vac_next   = cmd.vac;
                            state_next = S_APPLY;
                        end
                        csh_pkg::K_VICTIM:
                        begin
                            raddr      = '0;
                            cur_next   = '0;
                            state_next = S_SCAN;
                        end
                        csh_pkg::K_RANGE:
                        begin
                            out_valid_next = 1'b1;
                            victim_next    = '0;
                            status_next    = csh_pkg::ST_RANGE;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            victim_next    = '0;
                            status_next    = csh_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_APPLY:
            begin
                we    = 1'b1;
                wdata = e;
                case (op_reg)
                    csh_pkg::OP_HIT:
                    begin
                        if (e.usage != csh_pkg::USAGE_CAP)
                            wdata.usage = e.usage + 1'b1;
                    end
                    csh_pkg::OP_EVICT:
                    begin
                        wdata.usage = 2'd0;
                        wdata.valid = 1'b0;
                    end
                    csh_pkg::OP_NEW_TAG:
                    begin
                        wdata.usage = vac_reg ? 2'd0 : 2'd1;
                        wdata.valid = 1'b1;
                    end
                    default:
                    begin
                        wdata.pinned = 1'b0;
                    end
                endcase
                out_valid_next = 1'b1;
                victim_next    = '0;
                status_next    = csh_pkg::ST_OK;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                if (!e.valid && !e.pinned)
                begin
                    we             = 1'b1;
                    wdata.pinned   = 1'b1;
                    out_valid_next = 1'b1;
                    victim_next    = first_id + csh_pkg::ID_W'(cur_reg);
                    status_next    = csh_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
                else if (cur_inc >= live_n)
                begin
                    raddr      = start_c;
                    cur_next   = start_c;
                    hand_next  = next_c;
                    tries_next = csh_pkg::TRY_W'(32'(live_n) * csh_pkg::SWEEP_ROUNDS);
                    state_next = S_SWEEP;
                end
                else
                begin
                    raddr    = cur_inc[csh_pkg::IDX_W-1:0];
                    cur_next = cur_inc[csh_pkg::IDX_W-1:0];
                end
            end
            S_SWEEP:
            begin
                if (!e.pinned && e.usage == 2'd0)
                begin
                    we             = 1'b1;
                    wdata.pinned   = 1'b1;
                    out_valid_next = 1'b1;
                    victim_next    = first_id + csh_pkg::ID_W'(cur_reg);
                    status_next    = csh_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (!e.pinned)
                    begin
                        we          = 1'b1;
                        wdata.usage = e.usage >> 1;
                    end
                    if (tries_dec == '0)
                    begin
                        out_valid_next = 1'b1;
                        victim_next    = '0;
                        status_next    = csh_pkg::ST_NONE;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        raddr      = start_c;
                        cur_next   = start_c;
                        hand_next  = next_c;
                        tries_next = tries_dec;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // Forward a write that lands on the entry read in the same cycle
        fwd_valid_next = we && (waddr == raddr);
        fwd_data_next  = wdata;
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        tries_reg    <= tries_next;
        op_reg       <= op_next;
        vac_reg      <= vac_next;
        fwd_data_reg <= fwd_data_next;
        victim_reg   <= victim_next;
        status_reg   <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            hand_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hand_reg      <= hand_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/clock_sweep_halving_replacer.sv @@
// Clock sweep replacer, top level: configuration registers, front and back.
// Depends on csh_pkg, csh_front, csh_back.
//
// Replacement policy over up to 1024 buffer entries, each with a 2-bit usage
// count, a valid flag and a pin flag, kept in one on-chip RAM. After reset a
// clearing pass zeroes the RAM, one entry a cycle, and in_ready stays low
// meanwhile (configuration writes are still taken). Transactions enter a
// two-deep command queue, ids range-checked against first_id and entry_count
// on the way in, so the input side can take up to two transactions while a
// result waits on out_ready. A transaction is written into the queue
// registers before the back end can take it. The back end takes one command
// at a time: hit, evict, new tag and unpin are a RAM read then a write in the
// apply state, which loads the result register; out-of-range and unknown
// operations load the result register straight from idle. A victim request
// walks the RAM one entry a cycle looking for an invalid, unpinned entry
// among the N live entries and then, if needed, runs the clock sweep one
// entry a cycle for up to 3*N more entry visits.
// Write configuration only while the block is idle.
module clock_sweep_halving_replacer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic [csh_pkg::ID_W-1:0]    buffer_id,
    input  logic                        vacuum_load,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [csh_pkg::ID_W-1:0]    victim_id,
    output logic [1:0]                  status,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [csh_pkg::CFG_W-1:0]   cfg_data
);

    logic [csh_pkg::EC_W-1:0]   entry_count_reg, entry_count_next;
    logic [csh_pkg::ID_W-1:0]   first_id_reg, first_id_next;
    logic [csh_pkg::CNT_W-1:0]  live_n;
    logic                       cmd_valid;
    logic                       cmd_pop;
    csh_pkg::cmd_t              cmd;
    csh_pkg::back_status_t      back_st;

    // Clamp the entry count into 1..MAX_ENTRIES once, for both halves
    assign live_n = csh_pkg::live_count(entry_count_reg);

    always_comb
    begin
        entry_count_next = entry_count_reg;
        first_id_next    = first_id_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                csh_pkg::CFG_ENTRY_COUNT: entry_count_next = cfg_data[csh_pkg::EC_W-1:0];
                csh_pkg::CFG_FIRST_ID:    first_id_next    = cfg_data[csh_pkg::ID_W-1:0];
                default:                  entry_count_next = entry_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= csh_pkg::EC_W'(1024);
            first_id_reg    <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            first_id_reg    <= first_id_next;
        end
    end

    // Front: accept and classify transactions into the command queue
    csh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .buffer_id   (buffer_id),
        .vacuum_load (vacuum_load),
        .first_id    (first_id_reg),
        .live_n      (live_n),
        .back_st     (back_st),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Back: carry out commands against the entry RAM, hold the result
    csh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .live_n    (live_n),
        .first_id  (first_id_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .victim_id (victim_id),
        .status    (status),
        .back_st   (back_st)
    );

endmodule

@@ src/csh_checker.sv @@
// Port-level checker for the clock sweep replacer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module csh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] victim_id,
    input logic [1:0]  status
);

    `CSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `CSH_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(victim_id) && $stable(status), "result changed while stalled")
    `CSH_ASSERT_IMPL(a_status_code, out_valid, status != 2'd3, "undefined status code")
    `CSH_ASSERT_IMPL(a_err_zero_id, out_valid && status != 2'd0, victim_id == 16'd0, "nonzero id on failure")

endmodule

bind clock_sweep_halving_replacer csh_checker u_csh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .victim_id (victim_id),
    .status    (status)
);

@@ tb/clock_sweep_halving_replacer_tb.sv @@
// Testbench of the clock sweep replacer: directed and random transactions
// checked against a behavioural predictor. Depends on csh_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module clock_sweep_halving_replacer_tb;
    import csh_pkg::*;

    typedef struct packed {
        logic [2:0]      op;
        logic [ID_W-1:0] id;
        logic            vac;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0] victim;
        logic [1:0]      st;
    } answer_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          operation;
    logic [ID_W-1:0]     buffer_id;
    logic                vacuum_load;
    logic                out_valid;
    logic                out_ready;
    logic [ID_W-1:0]     victim_id;
    logic [1:0]          status;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    clock_sweep_halving_replacer dut (.*);

    // Predictor state: a private copy of the entry store and registers.
    logic [1:0]          model_usage [MAX_ENTRIES];
    logic                model_valid [MAX_ENTRIES];
    logic                model_pin   [MAX_ENTRIES];
    int unsigned         model_hand;
    int unsigned         model_count;
    int unsigned         model_first;

    request_t            pending_requests[$];
    answer_t             awaited_answers[$];
    int                  mismatches;
    int                  answers_seen;
    int                  victims_seen;
    int unsigned         cycle_count;
    int                  send_idle_pct;
    int                  take_idle_pct;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int unsigned entries_in_use();
        if (model_count == 0)
            return 1;
        if (model_count > MAX_ENTRIES)
            return MAX_ENTRIES;
        return model_count;
    endfunction

    // Work out the answer for one transaction and advance the model state.
    function automatic answer_t predict_answer(request_t r);
        answer_t     a;
        int unsigned n;
        int unsigned loc;
        int unsigned cur;
        bit          found;
        a = '0;
        n = entries_in_use();
        found = 0;
        if (r.op == OP_VICTIM) begin
            for (int i = 0; i < n && !found; i++)
                if (!model_valid[i] && !model_pin[i]) begin
                    found = 1;
                    loc = i;
                end
            for (int t = 0; t < n * SWEEP_ROUNDS && !found; t++) begin
                cur = (model_hand >= n) ? 0 : model_hand;
                model_hand = (cur + 1 >= n) ? 0 : cur + 1;
                if (model_pin[cur])
                    continue;
                if (model_usage[cur] != 0)
                    model_usage[cur] = model_usage[cur] >> 1;
                else begin
                    found = 1;
                    loc = cur;
                end
            end
            if (found) begin
                model_pin[loc] = 1'b1;
                a.victim = ID_W'(model_first + loc);
            end else
                a.st = ST_NONE;
        end else if (r.op <= OP_UNPIN) begin
            if (r.id < model_first || r.id - model_first >= n)
                a.st = ST_RANGE;
            else begin
                loc = r.id - model_first;
                case (r.op)
                    OP_HIT:
                        if (model_usage[loc] != USAGE_CAP)
                            model_usage[loc] = model_usage[loc] + 2'd1;
                    OP_EVICT:
                    begin
                        model_usage[loc] = 2'd0;
                        model_valid[loc] = 1'b0;
                    end
                    OP_NEW_TAG:
                    begin
                        model_usage[loc] = r.vac ? 2'd0 : 2'd1;
                        model_valid[loc] = 1'b1;
                    end
                    default:
                        model_pin[loc] = 1'b0;
                endcase
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d (answer %0d)",
                 what, got, want, answers_seen);
        mismatches++;
    endtask

    // Driver: present the next pending transaction, hold it until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            operation   <= OP_HIT;
            buffer_id   <= '0;
            vacuum_load <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid    <= 1'b1;
                operation   <= r.op;
                buffer_id   <= r.id;
                vacuum_load <= r.vac;
            end else
                in_valid <= 1'b0;
        end
    end

    // Predict at acceptance so the model follows transaction order.
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            awaited_answers.push_back(predict_answer('{operation, buffer_id, vacuum_load}));

    // Monitor: stall the result side at random, check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (out_valid && out_ready) begin
                answer_t want;
                answers_seen++;
                if (awaited_answers.size() == 0) begin
                    report_mismatch("result with nothing awaited", 1, 0);
                end else begin
                    want = awaited_answers.pop_front();
                    if (victim_id !== want.victim)
                        report_mismatch("victim_id", victim_id, want.victim);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (want.st == ST_OK && victim_id != 0)
                        victims_seen++;
                end
            end
            out_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Hard limit: the clearing pass, worst-case sweeps and stalls, many times over.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 10000000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic [2:0] op, input int unsigned id,
                                 input bit vac);
        pending_requests.push_back('{op, ID_W'(id), vac});
    endtask

    // Wait till every transaction has gone through, then let the back end drain.
    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || awaited_answers.size() != 0)
            @(posedge clk);
        repeat (4 * MAX_ENTRIES + 20) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ENTRY_COUNT)
            model_count = value & 11'h7FF;
        else
            model_first = value & 16'hFFFF;
    endtask

    // Mostly ids inside the pool, some just outside and some anywhere.
    function automatic int unsigned pick_id();
        int unsigned n;
        n = entries_in_use();
        case ($urandom_range(9))
            0: return $urandom_range(65535);
            1: return model_first + n + $urandom_range(3);
            2: return model_first - 1 - $urandom_range(2);
            default: return model_first + $urandom_range(n - 1);
        endcase
    endfunction

    task automatic random_phase(input int items);
        for (int k = 0; k < items; k++) begin
            int unsigned pick;
            pick = $urandom_range(99);
            if (pick < 30)
                queue_request(OP_HIT, pick_id(), $urandom_range(1));
            else if (pick < 42)
                queue_request(OP_EVICT, pick_id(), $urandom_range(1));
            else if (pick < 60)
                queue_request(OP_NEW_TAG, pick_id(), $urandom_range(1));
            else if (pick < 80)
                queue_request(OP_VICTIM, $urandom_range(65535), $urandom_range(1));
            else if (pick < 97)
                queue_request(OP_UNPIN, pick_id(), $urandom_range(1));
            else
                queue_request(3'($urandom_range(7, 5)), $urandom_range(65535),
                              $urandom_range(1));
        end
    endtask

    initial
    begin
        int unsigned settings [6][2];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ENTRY_COUNT;
        cfg_data = '0;
        mismatches = 0;
        answers_seen = 0;
        victims_seen = 0;
        cycle_count = 0;
        send_idle_pct = 31;
        take_idle_pct = 80;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            model_usage[i] = 2'd0;
            model_valid[i] = 1'b0;
            model_pin[i] = 1'b0;
        end
        model_hand = 0;
        model_count = 1024;
        model_first = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small pool at the top of the id space, then every operation.
        write_register(CFG_ENTRY_COUNT, 4);
        write_register(CFG_FIRST_ID, 16'hFFFE);
        queue_request(OP_NEW_TAG, 16'hFFFE, 1'b0);
        queue_request(OP_NEW_TAG, 16'hFFFF, 1'b1);
        queue_request(OP_HIT, 16'hFFFE, 1'b0);
        queue_request(OP_HIT, 16'hFFFE, 1'b0);
        queue_request(OP_HIT, 16'hFFFE, 1'b0);
        queue_request(OP_HIT, 16'hFFFE, 1'b0);       // usage saturates
        queue_request(OP_HIT, 16'h0000, 1'b0);       // beyond the wrap: out of range
        queue_request(OP_HIT, 16'hFFFD, 1'b0);       // below first id
        queue_request(OP_VICTIM, 16'hFFFF, 1'b1);    // ignored id and hint
        queue_request(OP_VICTIM, 16'h0000, 1'b0);    // wraps past 0xFFFF
        queue_request(OP_VICTIM, 0, 1'b0);           // sweep halves, then pins
        queue_request(OP_VICTIM, 0, 1'b0);
        queue_request(OP_VICTIM, 0, 1'b0);           // all pinned: no victim
        queue_request(OP_UNPIN, 16'hFFFF, 1'b0);
        queue_request(OP_UNPIN, 16'hFFFF, 1'b0);     // unpin twice is fine
        queue_request(OP_EVICT, 16'hFFFE, 1'b0);     // pin kept
        queue_request(OP_VICTIM, 0, 1'b0);
        queue_request(3'd5, 16'hFFFF, 1'b1);
        queue_request(3'd7, 0, 1'b0);
        queue_request(3'd6, 16'hFFFE, 1'b1);
        drain();
        // Shrink the pool to count zero under an advanced hand.
        write_register(CFG_ENTRY_COUNT, 0);
        queue_request(OP_NEW_TAG, 16'hFFFE, 1'b0);
        queue_request(OP_VICTIM, 0, 1'b0);
        queue_request(OP_UNPIN, 16'hFFFE, 1'b0);
        queue_request(OP_VICTIM, 0, 1'b1);
        drain();

        // Random phases across several pool settings, extremes among them.
        settings = '{'{8, 100}, '{2047, 0}, '{1, 65535}, '{1024, 64512},
                     '{3, 16'hFFFF}, '{37, 12345}};
        for (int s = 0; s < 6; s++) begin
            write_register(CFG_ENTRY_COUNT, settings[s][0]);
            write_register(CFG_FIRST_ID, settings[s][1]);
            if (s == 2) begin
                send_idle_pct = 80;
                take_idle_pct = 31;
            end else if (s == 4) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            random_phase(s == 1 || s == 3 ? 120 : 240);
            drain();
        end

        $display("Covered %0d results, %0d victims returned, over six pool settings",
                 answers_seen, victims_seen);
        if (mismatches == 0 && awaited_answers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ clock_sweep_halving_replacer.f @@
+incdir+src
src/csh_pkg.sv
src/csh_ram.sv
src/csh_front.sv
src/csh_back.sv
src/clock_sweep_halving_replacer.sv
src/csh_checker.sv
tb/clock_sweep_halving_replacer_tb.sv
